// File: rtl/bwe_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and word functions for the blitter area word engine.
// No dependencies; used by every module in the rtl folder.

package bwe_pkg;

    localparam int WORD_W            = 16;
    localparam int ROW_WORDS_W       = 7;
    localparam int CFG_INDEX_W       = 4;
    localparam int DEF_MAX_ROW_WORDS = 64;

    // control_zero bit positions
    localparam int C0_USE_A = 11;
    localparam int C0_USE_B = 10;
    localparam int C0_USE_C = 9;
    localparam int C0_USE_D = 8;

    // control_one bit positions
    localparam int C1_EXCL_FILL = 4;
    localparam int C1_INCL_FILL = 3;
    localparam int C1_FILL_CIN  = 2;
    localparam int C1_DESC      = 1;

    localparam logic [WORD_W-1:0]      MASK_RESET      = 16'hFFFF;
    localparam logic [ROW_WORDS_W-1:0] ROW_WORDS_RESET = 7'd64;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CONTROL_ZERO = 4'd0,
        REG_CONTROL_ONE  = 4'd1,
        REG_FIRST_MASK   = 4'd2,
        REG_LAST_MASK    = 4'd3,
        REG_ROW_WORDS    = 4'd4,
        REG_A_HOLD       = 4'd5,
        REG_B_HOLD       = 4'd6,
        REG_C_HOLD       = 4'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [WORD_W-1:0]      control_zero;
        logic [WORD_W-1:0]      control_one;
        logic [WORD_W-1:0]      first_word_mask;
        logic [WORD_W-1:0]      last_word_mask;
        logic [ROW_WORDS_W-1:0] row_words;
        logic [WORD_W-1:0]      a_hold;
        logic [WORD_W-1:0]      b_hold;
        logic [WORD_W-1:0]      c_hold;
    } cfg_t;

    typedef struct packed {
        logic              blit_begin;
        logic [WORD_W-1:0] c_fetched;
        logic [WORD_W-1:0] b_fetched;
        logic [WORD_W-1:0] a_fetched;
    } item_t;

    typedef struct packed {
        logic              row_last;
        logic              d_write;
        logic [WORD_W-1:0] d_word;
    } result_t;

    // Bit n of the minterm gives the output for the source bits {a, b, c} == n.
    function automatic logic [WORD_W-1:0] minterm_word(
        input logic [7:0]        lf,
        input logic [WORD_W-1:0] a,
        input logic [WORD_W-1:0] b,
        input logic [WORD_W-1:0] c
    );
        logic [WORD_W-1:0] d;
        d = '0;
        for (int i = 0; i < WORD_W; i++) begin
            d[i] = lf[{a[i], b[i], c[i]}];
        end
        return d;
    endfunction

    // Fill state at each bit is the carry XOR the parity of all source bits up to it.
    function automatic logic [WORD_W-1:0] fill_state(
        input logic [WORD_W-1:0] d,
        input logic              carry
    );
        logic [WORD_W-1:0] st;
        st = '0;
        for (int i = 0; i < WORD_W; i++) begin
            st[i] = carry ^ (^(d & ((WORD_W'(1) << i) | ((WORD_W'(1) << i) - 1'b1))));
        end
        return st;
    endfunction

endpackage

// File: rtl/bwe_cfg.sv
`timescale 1ns / 1ps
// Configuration register file for the blitter area word engine.
// Depends on bwe_pkg for the register index codes and the cfg_t bundle.

module bwe_cfg (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         wr_en,
    input  logic [bwe_pkg::CFG_INDEX_W-1:0] wr_index,
    input  logic [bwe_pkg::WORD_W-1:0]   wr_data,
    output bwe_pkg::cfg_t                cfg
);
    import bwe_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (cfg_reg_t'(wr_index))
                REG_CONTROL_ZERO: cfg_next.control_zero    = wr_data;
                REG_CONTROL_ONE:  cfg_next.control_one     = wr_data;
                REG_FIRST_MASK:   cfg_next.first_word_mask = wr_data;
                REG_LAST_MASK:    cfg_next.last_word_mask  = wr_data;
                REG_ROW_WORDS:    cfg_next.row_words       = wr_data[ROW_WORDS_W-1:0];
                REG_A_HOLD:       cfg_next.a_hold          = wr_data;
                REG_B_HOLD:       cfg_next.b_hold          = wr_data;
                REG_C_HOLD:       cfg_next.c_hold          = wr_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.control_zero    <= '0;
            cfg_reg.control_one     <= '0;
            cfg_reg.first_word_mask <= MASK_RESET;
            cfg_reg.last_word_mask  <= MASK_RESET;
            cfg_reg.row_words       <= ROW_WORDS_RESET;
            cfg_reg.a_hold          <= '0;
            cfg_reg.b_hold          <= '0;
            cfg_reg.c_hold          <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/bwe_dp.sv
`timescale 1ns / 1ps
// Word datapath: masking, barrel shift, minterm and fill, plus the row state.
// Depends on bwe_pkg for item, result and configuration types and word functions.

module bwe_dp #(
    parameter int MAX_ROW_WORDS = bwe_pkg::DEF_MAX_ROW_WORDS
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             advance,
    input  bwe_pkg::item_t   item,
    input  bwe_pkg::cfg_t    cfg,
    output bwe_pkg::result_t result
);
    import bwe_pkg::*;

    localparam int COL_W  = (MAX_ROW_WORDS > 1) ? $clog2(MAX_ROW_WORDS) : 1;
    localparam int LEN_LOG = $clog2(MAX_ROW_WORDS + 1);
    localparam int LEN_W  = (LEN_LOG > ROW_WORDS_W) ? LEN_LOG + 1 : ROW_WORDS_W + 1;

    logic [COL_W-1:0]  col_reg, col_next, col_cur;
    logic [WORD_W-1:0] prev_a_reg, prev_a_next, prev_a_cur;
    logic [WORD_W-1:0] prev_b_reg, prev_b_next, prev_b_cur;
    logic              carry_reg, carry_next, carry_cur;

    logic [LEN_W-1:0]      row_len, row_len_raw;
    logic                  last;
    logic [WORD_W-1:0]     a_src, b_src, c_src;
    logic [WORD_W-1:0]     a_mask, a_shift, b_shift;
    logic [2*WORD_W-1:0]   a_wide, b_wide;
    logic [WORD_W-1:0]     d_raw, st, d_fill;
    logic [3:0]            a_sh, b_sh;
    logic                  do_fill, excl, desc;

    always_comb begin
        row_len_raw = LEN_W'(cfg.row_words);
        if (row_len_raw == '0 || row_len_raw > LEN_W'(MAX_ROW_WORDS)) begin
            row_len = LEN_W'(MAX_ROW_WORDS);
        end else begin
            row_len = row_len_raw;
        end

        // A new blit clears the column and the previous words before use.
        col_cur    = item.blit_begin ? '0 : col_reg;
        prev_a_cur = item.blit_begin ? '0 : prev_a_reg;
        prev_b_cur = item.blit_begin ? '0 : prev_b_reg;

        last = LEN_W'(col_cur) >= (row_len - 1'b1);

        a_src = cfg.control_zero[C0_USE_A] ? item.a_fetched : cfg.a_hold;
        b_src = cfg.control_zero[C0_USE_B] ? item.b_fetched : cfg.b_hold;
        c_src = cfg.control_zero[C0_USE_C] ? item.c_fetched : cfg.c_hold;

        a_mask = a_src;
        if (col_cur == '0) begin
            a_mask = a_mask & cfg.first_word_mask;
        end
        if (last) begin
            a_mask = a_mask & cfg.last_word_mask;
        end
        carry_cur = (col_cur == '0) ? cfg.control_one[C1_FILL_CIN] : carry_reg;

        a_sh = cfg.control_zero[15:12];
        b_sh = cfg.control_one[15:12];
        desc = cfg.control_one[C1_DESC];
        if (!desc) begin
            a_wide  = {prev_a_cur, a_mask} >> a_sh;
            b_wide  = {prev_b_cur, b_src} >> b_sh;
            a_shift = a_wide[WORD_W-1:0];
            b_shift = b_wide[WORD_W-1:0];
        end else begin
            a_wide  = {a_mask, prev_a_cur} << a_sh;
            b_wide  = {b_src, prev_b_cur} << b_sh;
            a_shift = a_wide[2*WORD_W-1:WORD_W];
            b_shift = b_wide[2*WORD_W-1:WORD_W];
        end

        d_raw   = minterm_word(cfg.control_zero[7:0], a_shift, b_shift, c_src);
        excl    = cfg.control_one[C1_EXCL_FILL];
        do_fill = excl || cfg.control_one[C1_INCL_FILL];
        st      = fill_state(d_raw, carry_cur);
        d_fill  = excl ? st : (st | d_raw);

        result.d_word   = do_fill ? d_fill : d_raw;
        result.d_write  = cfg.control_zero[C0_USE_D];
        result.row_last = last;

        col_next    = last ? '0 : col_cur + 1'b1;
        prev_a_next = a_mask;
        prev_b_next = b_src;
        carry_next  = do_fill ? st[WORD_W-1] : carry_cur;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg    <= '0;
            prev_a_reg <= '0;
            prev_b_reg <= '0;
            carry_reg  <= 1'b0;
        end else if (advance) begin
            col_reg    <= col_next;
            prev_a_reg <= prev_a_next;
            prev_b_reg <= prev_b_next;
            carry_reg  <= carry_next;
        end
    end

    // The column only ever restarts after a word that ended its row or at a blit start.
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !result.row_last |=> col_reg != '0)
        else $error("column did not advance after a mid-row word");
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && result.row_last |=> col_reg == '0)
        else $error("column did not wrap after the last word of a row");
    assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(col_reg) && $stable(carry_reg))
        else $error("row state changed without a word moving through");

endmodule

// File: rtl/blitter_area_word_engine_core.sv
`timescale 1ns / 1ps
// Top level of the blitter area word engine: stream handshakes and register stages.
// Depends on bwe_pkg, bwe_cfg and bwe_dp.

// The engine takes one source word set per clock and returns one D word per clock
// while m_tready is held high. A transfer accepted on the s_ channel is held in an input
// register; the shift, minterm and fill logic turns it into a result that is loaded into
// the output register when that is free, and m_tvalid rises as it is loaded. The
// two stages stream back to back: the input side keeps taking transfers while a
// result waits, and stalls only when both registers are full. The cfg_ write
// channel is always ready; a written register takes effect from the next cycle, so
// it should only be written while no word is in flight.
module blitter_area_word_engine_core #(
    parameter int MAX_ROW_WORDS = bwe_pkg::DEF_MAX_ROW_WORDS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [47:0]                     s_tdata,  // a_fetched, b_fetched, c_fetched
    input  logic                            s_tuser,  // blit_begin
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [15:0]                     m_tdata,  // d_word
    output logic                            m_tuser,  // d_write
    output logic                            m_tlast,  // row_last
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bwe_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bwe_pkg::WORD_W-1:0]      cfg_data
);
    import bwe_pkg::*;

    cfg_t    cfg;
    item_t   in_reg;
    logic    in_vld_reg;
    result_t res;
    result_t out_reg;
    logic    out_vld_reg;
    logic    out_load;
    logic    s_xfer;

    assign cfg_ready = 1'b1;
    assign out_load  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready  = !in_vld_reg || out_load;
    assign s_xfer    = s_tvalid && s_tready;

    bwe_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    bwe_dp #(
        .MAX_ROW_WORDS (MAX_ROW_WORDS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (out_load),
        .item    (in_reg),
        .cfg     (cfg),
        .result  (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (s_xfer) begin
                in_vld_reg <= 1'b1;
            end else if (out_load) begin
                in_vld_reg <= 1'b0;
            end
            if (out_load) begin
                out_vld_reg <= 1'b1;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_reg.a_fetched  <= s_tdata[15:0];
            in_reg.b_fetched  <= s_tdata[31:16];
            in_reg.c_fetched  <= s_tdata[47:32];
            in_reg.blit_begin <= s_tuser;
        end
        if (out_load) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_reg.d_word;
    assign m_tuser  = out_reg.d_write;
    assign m_tlast  = out_reg.row_last;

    assert property (@(posedge aclk) disable iff (!aresetn)
        !in_vld_reg |-> s_tready)
        else $error("input stage empty but not ready");
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_tvalid)
        else $error("result register loaded but not presented");
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_vld_reg && out_vld_reg && !m_tready |-> !s_tready)
        else $error("input accepted while both stages are full");
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_vld_reg && !out_load |=> in_vld_reg)
        else $error("held input word dropped");

endmodule
